[design/i2cbm_pkg.sv]
// Package for the I2C bit-level master: transaction payload types and constants.
// Used by every module in the design folder; depends on nothing.
package i2cbm_pkg;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_failed;
  } out_t;

  localparam logic [2:0] ModeStart = 3'd1;
  localparam logic [2:0] ModeStop  = 3'd2;
  localparam logic [2:0] ModeWrite = 3'd3;
  localparam logic [2:0] ModeWait  = 3'd4;
  localparam logic [2:0] ModeRead  = 3'd5;

  localparam logic [15:0] AckLimitReset = 16'd500;

  localparam logic [4:0] TicksStart   = 5'd4;
  localparam logic [4:0] TicksStopMid = 5'd1;
  localparam logic [4:0] TicksBit     = 5'd5;
  localparam logic [4:0] TicksWait    = 5'd1;
  localparam logic [4:0] TicksAckLow  = 5'd20;
  localparam logic [4:0] TicksAckHigh = 5'd2;

endpackage

[design/i2c_bit_level_master.sv]
// Top level of the I2C bit-level master: input register, sequencer and result queue.
// Depends on i2cbm_pkg, i2cbm_ctrl and i2cbm_outq.
//
// Each input transaction is one microsecond tick: the sampled SDA level and, while
// the sequencer is idle, an optional command (start, stop, write byte, wait for
// acknowledge, read byte). Each tick yields exactly one result transaction with the
// SCL and SDA drive levels, busy and done flags, the last received byte and the
// acknowledge failure flag. Commands given while busy are ignored.
// A tick is held in the input register, then stepped through the sequencer, and its
// result is registered in a two-entry queue, from which it is offered.
// One tick is taken per cycle while in_stall is low, one sequencer step per tick.
// When the receiver stalls, results collect in the queue; once it holds two and a tick
// waits in the input register, the input channel stalls until the receiver takes one.
// The timeout register is written through cfg_we and cfg_data; write it only while no
// command is running, as the block itself does not enforce this.
// Reset empties the queue and the input register, returns the sequencer to idle
// with both lines released high, and sets the timeout limit to 500.
module i2c_bit_level_master (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cbm_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cbm_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data
);

  logic             tick_valid;
  i2cbm_pkg::in_t   tick;
  logic             full;
  logic             step;
  i2cbm_pkg::out_t  result;

  assign in_stall = tick_valid && full;
  assign step     = tick_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      tick <= in_data;
    end
  end

  i2cbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (step),
    .tick     (tick),
    .result   (result)
  );

  i2cbm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (result),
    .full      (full),
    .valid     (out_valid),
    .stall     (out_stall),
    .data      (out_data)
  );

endmodule

[design/i2cbm_ctrl.sv]
// Bus sequencer state and the per-tick step that turns one tick into one result.
// Uses i2cbm_pkg for the payload types, command codes and segment lengths.
module i2cbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              step,
  input  i2cbm_pkg::in_t    tick,
  output i2cbm_pkg::out_t   result
);

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_ST1    = 5'd1;
  localparam logic [4:0] PH_ST2    = 5'd2;
  localparam logic [4:0] PH_ST3    = 5'd3;
  localparam logic [4:0] PH_SP1    = 5'd4;
  localparam logic [4:0] PH_SP2    = 5'd5;
  localparam logic [4:0] PH_SP3    = 5'd6;
  localparam logic [4:0] PH_WR_SET = 5'd7;
  localparam logic [4:0] PH_WR_HI  = 5'd8;
  localparam logic [4:0] PH_WR_LO  = 5'd9;
  localparam logic [4:0] PH_WA1    = 5'd10;
  localparam logic [4:0] PH_WA2    = 5'd11;
  localparam logic [4:0] PH_WA_SMP = 5'd12;
  localparam logic [4:0] PH_RD_LO  = 5'd13;
  localparam logic [4:0] PH_RD_HI  = 5'd14;
  localparam logic [4:0] PH_AK1    = 5'd15;
  localparam logic [4:0] PH_AK2    = 5'd16;
  localparam logic [4:0] PH_AK3    = 5'd17;

  logic [15:0] ack_timeout_limit;
  logic [4:0]  phase, phase_next;
  logic [4:0]  delay_count, delay_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_value, shift_value_next;
  logic [15:0] timeout_count, timeout_count_next;
  logic        clock_drive, clock_drive_next;
  logic        data_drive, data_drive_next;
  logic        ack_choice, ack_choice_next;
  logic        fail_flag, fail_flag_next;
  logic [7:0]  rx_hold, rx_hold_next;

  logic        do_enter;
  logic        do_sample;
  logic        do_finish;
  logic [4:0]  target;
  logic [3:0]  bit_inc;

  always_comb begin
    phase_next         = phase;
    delay_count_next   = delay_count;
    bit_index_next     = bit_index;
    shift_value_next   = shift_value;
    timeout_count_next = timeout_count;
    clock_drive_next   = clock_drive;
    data_drive_next    = data_drive;
    ack_choice_next    = ack_choice;
    fail_flag_next     = fail_flag;
    rx_hold_next       = rx_hold;
    do_enter           = 1'b0;
    do_sample          = 1'b0;
    do_finish          = 1'b0;
    target             = PH_IDLE;
    bit_inc            = bit_index + 4'd1;

    if (phase == PH_IDLE) begin
      bit_index_next = 4'd0;
      case (tick.mode)
        i2cbm_pkg::ModeStart: begin
          do_enter = 1'b1;
          target   = PH_ST1;
        end
        i2cbm_pkg::ModeStop: begin
          do_enter = 1'b1;
          target   = PH_SP1;
        end
        i2cbm_pkg::ModeWrite: begin
          shift_value_next = tick.tx_byte;
          do_enter         = 1'b1;
          target           = PH_WR_SET;
        end
        i2cbm_pkg::ModeWait: begin
          timeout_count_next = 16'd0;
          fail_flag_next     = 1'b0;
          do_enter           = 1'b1;
          target             = PH_WA1;
        end
        i2cbm_pkg::ModeRead: begin
          ack_choice_next  = tick.send_ack;
          shift_value_next = 8'd0;
          do_enter         = 1'b1;
          target           = PH_RD_LO;
        end
        default: begin
        end
      endcase
    end else if (phase == PH_WA_SMP) begin
      do_sample = 1'b1;
    end else if (delay_count > 5'd1) begin
      delay_count_next = delay_count - 5'd1;
    end else begin
      case (phase)
        PH_ST1:    begin do_enter = 1'b1; target = PH_ST2;    end
        PH_ST2:    begin do_enter = 1'b1; target = PH_ST3;    end
        PH_SP1:    begin do_enter = 1'b1; target = PH_SP2;    end
        PH_SP2:    begin do_enter = 1'b1; target = PH_SP3;    end
        PH_WR_SET: begin do_enter = 1'b1; target = PH_WR_HI;  end
        PH_WR_HI:  begin do_enter = 1'b1; target = PH_WR_LO;  end
        PH_WA1:    begin do_enter = 1'b1; target = PH_WA2;    end
        PH_WA2:    begin do_enter = 1'b1; target = PH_WA_SMP; end
        PH_RD_LO:  begin do_enter = 1'b1; target = PH_RD_HI;  end
        PH_AK1:    begin do_enter = 1'b1; target = PH_AK2;    end
        PH_AK2:    begin do_enter = 1'b1; target = PH_AK3;    end
        PH_WR_LO: begin
          shift_value_next = {shift_value[6:0], 1'b0};
          bit_index_next   = bit_inc;
          if (bit_inc[3]) begin
            do_finish = 1'b1;
          end else begin
            do_enter = 1'b1;
            target   = PH_WR_SET;
          end
        end
        PH_RD_HI: begin
          bit_index_next = bit_inc;
          do_enter       = 1'b1;
          if (bit_inc[3]) begin
            rx_hold_next = shift_value;
            target       = PH_AK1;
          end else begin
            target = PH_RD_LO;
          end
        end
        default: begin
          do_finish = 1'b1;
        end
      endcase
    end

    if (do_enter) begin
      phase_next = target;
      case (target)
        PH_ST1: begin
          clock_drive_next = 1'b1; data_drive_next = 1'b1;
          delay_count_next = i2cbm_pkg::TicksStart;
        end
        PH_ST2: begin
          clock_drive_next = 1'b1; data_drive_next = 1'b0;
          delay_count_next = i2cbm_pkg::TicksStart;
        end
        PH_ST3, PH_SP1: begin
          clock_drive_next = 1'b0; data_drive_next = 1'b0;
          delay_count_next = i2cbm_pkg::TicksStart;
        end
        PH_SP2: begin
          clock_drive_next = 1'b1; data_drive_next = 1'b0;
          delay_count_next = i2cbm_pkg::TicksStopMid;
        end
        PH_SP3: begin
          clock_drive_next = 1'b1; data_drive_next = 1'b1;
          delay_count_next = i2cbm_pkg::TicksStart;
        end
        PH_WR_SET: begin
          clock_drive_next = 1'b0; data_drive_next = shift_value_next[7];
          delay_count_next = i2cbm_pkg::TicksBit;
        end
        PH_WR_HI: begin
          clock_drive_next = 1'b1;
          delay_count_next = i2cbm_pkg::TicksBit;
        end
        PH_WR_LO: begin
          clock_drive_next = 1'b0;
          delay_count_next = i2cbm_pkg::TicksBit;
        end
        PH_WA1: begin
          data_drive_next  = 1'b1;
          delay_count_next = i2cbm_pkg::TicksWait;
        end
        PH_WA2: begin
          clock_drive_next = 1'b1; data_drive_next = 1'b1;
          delay_count_next = i2cbm_pkg::TicksWait;
        end
        PH_WA_SMP: begin
          clock_drive_next = 1'b1; data_drive_next = 1'b1;
          delay_count_next = 5'd0;
          do_sample        = 1'b1;
        end
        PH_RD_LO: begin
          clock_drive_next = 1'b0; data_drive_next = 1'b1;
          delay_count_next = i2cbm_pkg::TicksBit;
        end
        PH_RD_HI: begin
          clock_drive_next = 1'b1; data_drive_next = 1'b1;
          delay_count_next = i2cbm_pkg::TicksBit;
          shift_value_next = {shift_value_next[6:0], tick.sda_sample};
        end
        PH_AK1: begin
          clock_drive_next = 1'b0;
          data_drive_next  = ~ack_choice_next;
          delay_count_next = ack_choice_next ? i2cbm_pkg::TicksAckLow : i2cbm_pkg::TicksBit;
        end
        PH_AK2: begin
          clock_drive_next = 1'b1;
          delay_count_next = ack_choice_next ? i2cbm_pkg::TicksAckHigh : i2cbm_pkg::TicksBit;
        end
        PH_AK3: begin
          clock_drive_next = 1'b0;
          delay_count_next = 5'd0;
          do_finish        = 1'b1;
        end
        default: begin
          do_finish = 1'b1;
        end
      endcase
    end

    if (do_sample) begin
      if (!tick.sda_sample) begin
        clock_drive_next = 1'b0;
        do_finish        = 1'b1;
      end else if (timeout_count_next >= ack_timeout_limit) begin
        fail_flag_next   = 1'b1;
        phase_next       = PH_SP1;
        clock_drive_next = 1'b0;
        data_drive_next  = 1'b0;
        delay_count_next = i2cbm_pkg::TicksStart;
      end else begin
        timeout_count_next = timeout_count_next + 16'd1;
      end
    end

    if (do_finish) begin
      phase_next       = PH_IDLE;
      delay_count_next = 5'd0;
    end

    result.scl_level  = clock_drive_next;
    result.sda_level  = data_drive_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = do_finish;
    result.rx_data    = rx_hold_next;
    result.ack_failed = fail_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_limit <= i2cbm_pkg::AckLimitReset;
    end else if (cfg_we) begin
      ack_timeout_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      delay_count   <= 5'd0;
      bit_index     <= 4'd0;
      shift_value   <= 8'd0;
      timeout_count <= 16'd0;
      clock_drive   <= 1'b1;
      data_drive    <= 1'b1;
      ack_choice    <= 1'b0;
      fail_flag     <= 1'b0;
      rx_hold       <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      bit_index     <= bit_index_next;
      shift_value   <= shift_value_next;
      timeout_count <= timeout_count_next;
      clock_drive   <= clock_drive_next;
      data_drive    <= data_drive_next;
      ack_choice    <= ack_choice_next;
      fail_flag     <= fail_flag_next;
      rx_hold       <= rx_hold_next;
    end
  end

endmodule

[design/i2cbm_outq.sv]
// Two-entry result queue that holds finished results while the receiver stalls.
// Uses i2cbm_pkg for the result payload type.
module i2cbm_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cbm_pkg::out_t  push_data,
  output logic             full,
  output logic             valid,
  input  logic             stall,
  output i2cbm_pkg::out_t  data
);

  i2cbm_pkg::out_t entry [2];
  logic       head;
  logic [1:0] count;
  logic       pop;
  logic       tail;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign data  = entry[head];
  assign pop   = valid && !stall;
  assign tail  = head ^ count[0];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) begin
        head <= ~head;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
